// ===== rtl/svc_nlf_pkg.sv =====
`default_nettype none

package svc_nlf_pkg;

   localparam int NUM_SLOTS = 8;          // most bytes one input beat can release
   localparam int CNT_W     = 4;

   localparam logic [4:0] NAL_TYPE_NON_IDR   = 5'd1;
   localparam logic [4:0] NAL_TYPE_IDR       = 5'd5;
   localparam logic [4:0] NAL_TYPE_SEI       = 5'd6;
   localparam logic [4:0] NAL_TYPE_PREFIX    = 5'd14;
   localparam logic [4:0] NAL_TYPE_EXT_SLICE = 5'd20;

   localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
   localparam logic [7:0] DID_MASK      = 8'h70;
   localparam logic [7:0] QID_MASK      = 8'h0F;
   localparam logic [7:0] TID_MASK      = 8'hE0;

   localparam logic [1:0] CSR_MAX_DID = 2'd0;
   localparam logic [1:0] CSR_MAX_QID = 2'd1;
   localparam logic [1:0] CSR_MAX_TID = 2'd2;

   typedef enum logic [2:0] {
      PH_PAYLOAD,
      PH_HEADER,
      PH_EXT1,
      PH_EXT2,
      PH_EXT3
   } phase_type;

   typedef struct packed {
      logic [2:0] max_did;
      logic [3:0] max_qid;
      logic [2:0] max_tid;
   } cfg_type;

   // one queue entry: the bytes released by one input beat
   typedef struct packed {
      logic [NUM_SLOTS-1:0][7:0] byte_list;
      logic [CNT_W-1:0]          cnt;
      logic                      fin;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/svc_nlf_front.sv =====
`default_nettype none

module svc_nlf_front
   import svc_nlf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      accept,
   input  wire logic [7:0] in_byte,
   input  wire logic      in_final,
   output logic           push_valid,
   output entry_type      push_entry
);

   phase_type  phase_ff, phase_in, phase_nx;
   logic [1:0] zr_ff, zr_in;
   logic [7:0] hdr_ff, hdr_in;
   logic [7:0] e0_ff, e0_in;
   logic [7:0] e1_ff, e1_in;
   logic       keep_ff, keep_in;
   logic [4:0] lt_ff, lt_in;

   logic [4:0] nal_t;
   logic       is_ext_t;
   logic       chain_drop;
   logic       layer_ok;
   logic [2:0] did, tid;
   logic [3:0] qid;

   logic [1:0] z, f;
   logic [2:0] tl;
   logic [NUM_SLOTS-1:0][7:0] tail;
   logic [CNT_W-1:0] total;
   logic [2:0] sel;

   assign nal_t      = 5'(in_byte & NAL_TYPE_MASK);
   assign is_ext_t   = nal_t inside {NAL_TYPE_PREFIX, NAL_TYPE_EXT_SLICE};
   assign chain_drop = (nal_t inside {NAL_TYPE_NON_IDR, NAL_TYPE_IDR, NAL_TYPE_SEI}) &&
                       (lt_ff inside {NAL_TYPE_PREFIX, NAL_TYPE_EXT_SLICE}) && !keep_ff;
   assign did        = 3'((e1_ff & DID_MASK) >> 4);
   assign qid        = 4'(e1_ff & QID_MASK);
   assign tid        = 3'((in_byte & TID_MASK) >> 5);
   assign layer_ok   = (did <= cfg.max_did) && (qid <= cfg.max_qid) && (tid <= cfg.max_tid);

   // next state of the parser, before the end of stream is applied
   always_comb begin
      phase_nx = phase_ff;
      case (phase_ff)
         PH_PAYLOAD: begin
            if (in_byte == 8'd1 && zr_ff >= 2'd2) phase_nx = PH_HEADER;
         end
         PH_HEADER: begin
            if (!chain_drop && is_ext_t) phase_nx = PH_EXT1;
            else phase_nx = PH_PAYLOAD;
         end
         PH_EXT1: phase_nx = PH_EXT2;
         PH_EXT2: phase_nx = PH_EXT3;
         PH_EXT3: phase_nx = PH_PAYLOAD;
         default: phase_nx = PH_PAYLOAD;
      endcase
   end

   assign phase_in = in_final ? PH_PAYLOAD : phase_nx;

   // released bytes: z held zeros, tl tail bytes, then f flushed zeros
   always_comb begin
      zr_in   = zr_ff;
      hdr_in  = hdr_ff;
      e0_in   = e0_ff;
      e1_in   = e1_ff;
      keep_in = keep_ff;
      lt_in   = lt_ff;
      z       = 2'd0;
      f       = 2'd0;
      tl      = 3'd0;
      tail    = '0;
      case (phase_ff)
         PH_PAYLOAD: begin
            if (in_byte == 8'd0) begin
               if (zr_ff != 2'd3) begin
                  zr_in = zr_ff + 2'd1;
               end else if (keep_ff) begin
                  tl = 3'd1;   // oldest held zero is pushed out
               end
            end else if (!(in_byte == 8'd1 && zr_ff >= 2'd2)) begin
               if (keep_ff) begin
                  z       = zr_ff;
                  tail[0] = in_byte;
                  tl      = 3'd1;
               end
               zr_in = 2'd0;
            end
         end
         PH_HEADER: begin
            hdr_in = in_byte;
            if (chain_drop) begin
               zr_in = 2'd0;
            end else if (is_ext_t) begin
               lt_in = nal_t;
            end else begin
               lt_in   = nal_t;
               keep_in = 1'b1;
               z       = zr_ff;
               tail[0] = 8'd1;
               tail[1] = in_byte;
               tl      = 3'd2;
               zr_in   = 2'd0;
            end
         end
         PH_EXT1: e0_in = in_byte;
         PH_EXT2: e1_in = in_byte;
         PH_EXT3: begin
            zr_in = 2'd0;
            if (layer_ok) begin
               keep_in = 1'b1;
               z       = zr_ff;
               tail[0] = 8'd1;
               tail[1] = hdr_ff;
               tail[2] = e0_ff;
               tail[3] = e1_ff;
               tail[4] = in_byte;
               tl      = 3'd5;
            end else begin
               keep_in = 1'b0;
            end
         end
         default: ;
      endcase
      if (in_final) begin
         // a unit cut off in its start code tail, header or extension is discarded
         if (phase_nx == PH_PAYLOAD && keep_in) f = zr_in;
         zr_in   = 2'd0;
         keep_in = 1'b1;
         lt_in   = 5'd0;
         hdr_in  = 8'd0;
      end
   end

   assign total = {2'b00, z} + {1'b0, tl} + {2'b00, f};

   always_comb begin
      push_entry.fin = in_final;
      push_entry.cnt = (total > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : total;
      sel = 3'd0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         sel = 3'(i) - {1'b0, z};
         if (CNT_W'(i) < {2'b00, z}) begin
            push_entry.byte_list[i] = 8'd0;
         end else if (CNT_W'(i) < {2'b00, z} + {1'b0, tl}) begin
            push_entry.byte_list[i] = tail[sel];
         end else begin
            push_entry.byte_list[i] = 8'd0;
         end
      end
   end

   assign push_valid = accept && (push_entry.cnt != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PAYLOAD;
         zr_ff    <= 2'd0;
         keep_ff  <= 1'b1;
         lt_ff    <= 5'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         zr_ff    <= zr_in;
         keep_ff  <= keep_in;
         lt_ff    <= lt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff <= hdr_in;
         e0_ff  <= e0_in;
         e1_ff  <= e1_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/svc_nlf_queue.sv =====
`default_nettype none

module svc_nlf_queue
   import svc_nlf_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output logic           full,
   output logic           head_valid,
   output entry_type      head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CT_W  = $clog2(DEPTH + 1);

   entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == CT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (push && !pop) count_in = count_ff + CT_W'(1);
      else if (pop && !push) count_in = count_ff - CT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

// ===== rtl/svc_nlf_back.sv =====
`default_nettype none

module svc_nlf_back
   import svc_nlf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire entry_type  head_entry,
   output logic            pop,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,
   output logic            rsp_tlast,
   output logic            rsp_tuser
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff, end_ff;
   logic       load, is_last;

   // output register takes a new beat when empty or being drained
   assign load    = head_valid && (!valid_ff || rsp_tready);
   assign is_last = ({1'b0, idx_ff} == head_entry.cnt - CNT_W'(1));
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = is_last ? 3'd0 : idx_ff + 3'd1;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= head_entry.byte_list[idx_ff];
         last_ff <= is_last;
         end_ff  <= is_last && head_entry.fin;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = end_ff;

endmodule

`default_nettype wire

// ===== rtl/svc_nal_layer_filter_top.sv =====
// SVC NAL layer filter. Takes an Annex B byte stream one byte per req_ beat, finds
// 00 00 01 start codes and drops NAL units of type 14/20 whose dependency, quality or
// temporal id exceeds the csr_ limits, plus any type 1/5/6 units that follow such a
// dropped unit; everything else passes through byte for byte with its start code.
// Input is taken every cycle while the entry queue (QUEUE_DEPTH entries) has room;
// each input beat that releases k bytes (0 to 8) leaves as k rsp_ beats, one per
// cycle while rsp_tready is high, through the queue entry and the output register.
// Zeros before a start code and the header/extension bytes are held until the keep
// decision, so a held zero can wait for up to seven later input beats. rsp_tlast
// marks the last byte released by one input beat, rsp_tuser the end of the stream.
// csr_ready is always high; write registers only while the block is idle.
`default_nettype none

module svc_nal_layer_filter_top
   import svc_nlf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // in_byte
   input  wire logic       req_tlast,    // in_final
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // out_byte
   output logic            rsp_tlast,    // run_end
   output logic            rsp_tuser,    // stream_end
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [3:0] csr_data
);

   cfg_type   cfg_ff;
   logic      accept;
   logic      q_push, q_pop, q_full, q_valid;
   entry_type q_in, q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_did <= 3'd7;
         cfg_ff.max_qid <= 4'd15;
         cfg_ff.max_tid <= 3'd7;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_DID: cfg_ff.max_did <= csr_data[2:0];
            CSR_MAX_QID: cfg_ff.max_qid <= csr_data;
            CSR_MAX_TID: cfg_ff.max_tid <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   svc_nlf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .in_byte    (req_tdata),
      .in_final   (req_tlast),
      .push_valid (q_push),
      .push_entry (q_in)
   );

   svc_nlf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   svc_nlf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_entry (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("stream end flagged on a beat that is not the last of its run");

   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> q_head.cnt != '0 && q_head.cnt <= CNT_W'(NUM_SLOTS))
      else $error("queue head holds an entry with a bad byte count");

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_tvalid && rsp_tlast)
      else $error("entry popped without its last beat in the output register");

endmodule

`default_nettype wire
